### src/twlru_pkg.sv
`default_nettype none

package twlru_pkg;

    // instruction opcodes
    localparam logic [5:0] OP_LOAD  = 6'd35;
    localparam logic [5:0] OP_STORE = 6'd43;

    // rt window that maps onto the register file
    localparam int unsigned REG_BASE  = 16;
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned REG_BITS  = 3;

    // backing memory word i comes out of reset holding i plus this bias
    localparam int unsigned INIT_BIAS = 5;

    // result status codes
    typedef enum logic [2:0] {
        ST_UNKNOWN    = 3'd0,
        ST_LOAD_HIT   = 3'd1,
        ST_LOAD_MISS  = 3'd2,
        ST_STORE_HIT  = 3'd3,
        ST_STORE_MISS = 3'd4,
        ST_BAD_REG    = 3'd5
    } t_status;

endpackage

`default_nettype wire

### src/two_way_lru_cache_load_store_unit.sv
// a transaction accepted in S_IDLE moves to S_LOOK with its cache set row and backing memory word
// read into registers; its result is registered on leaving S_LOOK, which waits while an earlier result stalls
// one transaction at a time: the input is not ready during the read-then-write of the cache set
// and backing memory entries, each a synchronous memory; reset: synchronous active low, afterwards
// all MEM_WORDS backing memory words (128 by default) are loaded while the input is not ready
// NUM_SETS and MEM_WORDS are powers of two with MEM_WORDS larger than NUM_SETS
`default_nettype none

module two_way_lru_cache_load_store_unit
    import twlru_pkg::*;
#(
    parameter int NUM_SETS  = 8,
    parameter int MEM_WORDS = 128,
    parameter int WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_instr_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_load_data,
    output logic [2:0]       o_dest_reg
);

    localparam int ADDR_BITS = $clog2(MEM_WORDS);
    localparam int SET_BITS  = $clog2(NUM_SETS);
    localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
    localparam int LINE_BITS = TAG_BITS + WORD_BITS;
    localparam int LD_BITS   = (WORD_BITS < 32) ? WORD_BITS : 32;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    // state machine and result registers
    t_state                r_state;
    logic                  r_out_valid;
    t_status               r_status;
    logic [31:0]           r_load_data;
    logic [REG_BITS-1:0]   r_dest_reg;

    // decoded transaction
    logic                  r_is_load;
    logic                  r_is_access;
    logic                  r_bad_reg;
    logic [REG_BITS-1:0]   r_idx;
    logic [ADDR_BITS-1:0]  r_addr;

    // cache state: tag/data rows in memory, valid and recent bits in flops
    logic [1:0][LINE_BITS-1:0] r_cache_mem [NUM_SETS];
    logic [1:0][LINE_BITS-1:0] r_cache_rd;
    logic [1:0]                r_valid [NUM_SETS];
    logic [NUM_SETS-1:0]       r_recent;
    logic [WORD_BITS-1:0]      r_reg_file [REG_COUNT];

    logic                  accept;
    logic                  advance;
    logic [5:0]            in_op;
    logic [4:0]            in_rt;
    logic [ADDR_BITS-1:0]  in_addr;
    logic [SET_BITS-1:0]   set;
    logic [TAG_BITS-1:0]   tag;
    logic [1:0]            set_valid;
    logic                  hit0;
    logic                  hit1;
    logic                  hit;
    logic                  hit_way;
    logic                  victim;
    logic [WORD_BITS-1:0]  hit_word;
    logic [WORD_BITS-1:0]  reg_word;
    logic [WORD_BITS-1:0]  mem_rd_data;
    logic                  init_done;

    logic                      cache_we;
    logic [1:0][LINE_BITS-1:0] cache_wr_row;
    logic                      mem_we;
    logic [ADDR_BITS-1:0]      mem_wr_addr;
    logic [WORD_BITS-1:0]      mem_wr_data;
    logic                      reg_we;
    logic [WORD_BITS-1:0]      reg_wr_data;

    t_state                n_state;
    logic                  n_out_valid;
    t_status               n_status;
    logic [31:0]           n_load_data;
    logic [REG_BITS-1:0]   n_dest_reg;

    // input decode
    assign in_op   = i_instr_word[31:26];
    assign in_rt   = i_instr_word[20:16];
    assign in_addr = i_instr_word[ADDR_BITS+1:2];

    assign o_in_ready = (r_state == S_IDLE) && init_done;
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    // lookup against the registered set row
    assign set       = r_addr[SET_BITS-1:0];
    assign tag       = r_addr[ADDR_BITS-1:SET_BITS];
    assign set_valid = r_valid[set];
    assign hit0      = set_valid[0] && (r_cache_rd[0][LINE_BITS-1:WORD_BITS] == tag);
    assign hit1      = set_valid[1] && (r_cache_rd[1][LINE_BITS-1:WORD_BITS] == tag);
    assign hit       = hit0 || hit1;
    assign hit_way   = !hit0;
    assign hit_word  = r_cache_rd[hit_way][WORD_BITS-1:0];
    assign reg_word  = r_reg_file[r_idx];

    // victim: first invalid way, else the way not used last
    always_comb begin
        if (!set_valid[0]) begin
            victim = 1'b0;
        end else if (!set_valid[1]) begin
            victim = 1'b1;
        end else begin
            victim = !r_recent[set];
        end
    end

    // write-back, fill and register update decisions
    always_comb begin
        cache_we     = 1'b0;
        cache_wr_row = r_cache_rd;
        mem_we       = 1'b0;
        mem_wr_addr  = r_addr;
        mem_wr_data  = reg_word;
        reg_we       = 1'b0;
        reg_wr_data  = hit_word;
        if (advance && r_is_access && !r_bad_reg) begin
            if (hit) begin
                if (r_is_load) begin
                    reg_we = 1'b1;
                end else begin
                    cache_we = 1'b1;
                    cache_wr_row[hit_way] = {r_cache_rd[hit_way][LINE_BITS-1:WORD_BITS], reg_word};
                end
            end else if (!r_is_load) begin
                mem_we = 1'b1;
            end else begin
                cache_we    = 1'b1;
                cache_wr_row[victim] = {tag, mem_rd_data};
                reg_we      = 1'b1;
                reg_wr_data = mem_rd_data;
                mem_we      = set_valid[victim];
                mem_wr_addr = {r_cache_rd[victim][LINE_BITS-1:WORD_BITS], set};
                mem_wr_data = r_cache_rd[victim][WORD_BITS-1:0];
            end
        end
    end

    // next state and result
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_load_data = r_load_data;
        n_dest_reg  = r_dest_reg;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (advance) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_load_data = '0;
                    n_dest_reg  = '0;
                    if (!r_is_access) begin
                        n_status = ST_UNKNOWN;
                    end else if (r_bad_reg) begin
                        n_status = ST_BAD_REG;
                    end else begin
                        n_dest_reg = r_idx;
                        if (hit && r_is_load) begin
                            n_status    = ST_LOAD_HIT;
                            n_load_data = 32'(hit_word[LD_BITS-1:0]);
                        end else if (hit) begin
                            n_status = ST_STORE_HIT;
                        end else if (!r_is_load) begin
                            n_status = ST_STORE_MISS;
                        end else begin
                            n_status    = ST_LOAD_MISS;
                            n_load_data = 32'(mem_rd_data[LD_BITS-1:0]);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_status    <= n_status;
        r_load_data <= n_load_data;
        r_dest_reg  <= n_dest_reg;
    end

    // capture decoded transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_load   <= (in_op == OP_LOAD);
            r_is_access <= (in_op == OP_LOAD) || (in_op == OP_STORE);
            r_bad_reg   <= (in_rt < 5'(REG_BASE)) || (in_rt >= 5'(REG_BASE + REG_COUNT));
            r_idx       <= in_rt[REG_BITS-1:0];
            r_addr      <= in_addr;
        end
    end

    // cache row memory
    always_ff @(posedge i_clk) begin
        if (cache_we) begin
            r_cache_mem[set] <= cache_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cache_rd <= r_cache_mem[in_addr[SET_BITS-1:0]];
        end
    end

    // valid and recently-used bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
            end
            r_recent <= '0;
        end else if (advance && r_is_access && !r_bad_reg) begin
            if (hit) begin
                r_recent[set] <= hit_way;
            end else if (r_is_load) begin
                r_valid[set][victim] <= 1'b1;
                r_recent[set]        <= victim;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < REG_COUNT; r++) begin
                r_reg_file[r] <= '0;
            end
        end else if (reg_we) begin
            r_reg_file[r_idx] <= reg_wr_data;
        end
    end

    // backing memory with its init sweep
    twlru_backing_mem #(
        .MEM_WORDS (MEM_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_backing_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr   (in_addr),
        .o_rd_data   (mem_rd_data),
        .i_wr_en     (mem_we),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .o_init_done (init_done)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_load_data = r_load_data;
    assign o_dest_reg  = r_dest_reg;

endmodule

`default_nettype wire

### src/twlru_backing_mem.sv
`default_nettype none

module twlru_backing_mem
    import twlru_pkg::*;
#(
    parameter int MEM_WORDS = 128,
    parameter int WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(MEM_WORDS)-1:0] i_rd_addr,
    output logic      [WORD_BITS-1:0]         o_rd_data,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(MEM_WORDS)-1:0] i_wr_addr,
    input  wire logic [WORD_BITS-1:0]         i_wr_data,
    output logic                              o_init_done
);

    localparam int ADDR_BITS = $clog2(MEM_WORDS);

    logic [WORD_BITS-1:0] r_mem [MEM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [ADDR_BITS-1:0] r_init_addr;
    logic                 r_init_busy;
    logic [ADDR_BITS:0]   init_sum;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // init value: address plus bias, masked to the word width
    assign init_sum = {1'b0, r_init_addr} + (ADDR_BITS+1)'(INIT_BIAS);

    // sweep owns the write port until the last word is loaded
    always_comb begin
        if (r_init_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_init_addr;
            wr_data = WORD_BITS'(init_sum);
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    // init sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_addr <= '0;
        end else if (r_init_busy) begin
            r_init_addr <= r_init_addr + 1'b1;
            if (r_init_addr == ADDR_BITS'(MEM_WORDS - 1)) begin
                r_init_busy <= 1'b0;
            end
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_init_done = !r_init_busy;

endmodule

`default_nettype wire

### src/twlru_checker.sv
`default_nettype none

module twlru_checker
    import twlru_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_load_data,
    input wire logic [2:0]  o_dest_reg
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_load_data) && $stable(o_dest_reg))
        else $error("stalled result changed");

    // status stays within the defined codes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= 3'(ST_BAD_REG))
        else $error("status code out of range");

    // only loads carry data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !(o_status == 3'(ST_LOAD_HIT) || o_status == 3'(ST_LOAD_MISS))
            |-> o_load_data == 32'd0)
        else $error("load data on a non-load result");

    // rejected transactions name no register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == 3'(ST_UNKNOWN) || o_status == 3'(ST_BAD_REG))
            |-> o_dest_reg == 3'd0)
        else $error("register named on a rejected transaction");

    // one transaction in flight at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a transaction is in flight");

endmodule

bind two_way_lru_cache_load_store_unit twlru_checker u_twlru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_load_data (o_load_data),
    .o_dest_reg  (o_dest_reg)
);

`default_nettype wire
